### hdl/tdm_pkg.sv
package tdm_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] FullRateReset    = 16'd15000;
  localparam logic [15:0] ReducedRateReset = 16'd7000;
  localparam logic [6:0]  TrackDzReset     = 7'd7;
  localparam logic [6:0]  SteerDzReset     = 7'd7;

  localparam logic [7:0] MODE_MIX_FULL    = 8'd0;
  localparam logic [7:0] MODE_MIX_REDUCED = 8'd1;
  localparam logic [7:0] MODE_STICKS      = 8'd2;
  localparam logic [7:0] MODE_ARROWS      = 8'd3;
  localparam logic [7:0] MODE_TRIG_HALF   = 8'd4;
  localparam logic [7:0] MODE_TRIG_INV    = 8'd5;

  typedef enum logic [1:0] {
    REG_FULL_RATE    = 2'd0,
    REG_REDUCED_RATE = 2'd1,
    REG_TRACK_DZ     = 2'd2,
    REG_STEER_DZ     = 2'd3
  } cfg_reg_e;

  localparam logic signed [8:0] TrigOffset   = 9'sd100;
  localparam logic signed [8:0] MixFullScale = 9'sd101;
  localparam logic signed [8:0] ArrowFull    = 9'sd100;

  // floor(m / 101) = (m * MixDivK) >> MixDivShift for m < 2**14
  localparam int unsigned   MixDivShift = 21;
  localparam logic [14:0]   MixDivK     = 15'd20764;
  // floor(y / 25) = (y * SpeedDivK) >> SpeedDivShift for y < 2**22
  localparam int unsigned   SpeedDivShift = 27;
  localparam logic [22:0]   SpeedDivK     = 23'd5368710;
  localparam logic [16:0]   SpeedMax      = 17'h1FFFF;

  typedef struct packed {
    logic [15:0] full_rate;
    logic [15:0] reduced_rate;
    logic [6:0]  track_dz;
    logic [6:0]  steer_dz;
  } cfg_t;

  typedef struct packed {
    logic [8:0] right_target;
    logic [8:0] left_target;
    logic       reduced;
  } track_cmd_t;

  function automatic logic signed [8:0] dead_zone(logic signed [8:0] x, logic [6:0] z);
    logic signed [8:0] zs;
    logic signed [8:0] res;
    zs = $signed({2'b00, z});
    if (x < zs && x > -zs) begin
      res = 9'sd0;
    end else if (x > 9'sd0) begin
      res = x - zs;
    end else begin
      res = x + zs;
    end
    return res;
  endfunction

  function automatic logic signed [8:0] arrow_right_target(logic [3:0] idx);
    logic signed [8:0] res;
    case (idx)
      4'd1, 4'd8, 4'd9:  res = ArrowFull;
      4'd2, 4'd4, 4'd12: res = -ArrowFull;
      default:           res = 9'sd0;
    endcase
    return res;
  endfunction

  function automatic logic signed [8:0] arrow_left_target(logic [3:0] idx);
    logic signed [8:0] res;
    case (idx)
      4'd1, 4'd2, 4'd3: res = ArrowFull;
      4'd4, 4'd6, 4'd8: res = -ArrowFull;
      default:          res = 9'sd0;
    endcase
    return res;
  endfunction

endpackage

### hdl/tdm_queue.sv
module tdm_queue #(
  parameter int unsigned Width = 19,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hdl/tdm_front.sv
module tdm_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tdm_pkg::cfg_t          cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   arrow_up_i,
  input  logic                   arrow_right_i,
  input  logic                   arrow_down_i,
  input  logic                   arrow_left_i,
  input  logic signed [7:0]      steer_axis_i,
  input  logic signed [7:0]      left_stick_axis_i,
  input  logic signed [7:0]      left_trigger_i,
  input  logic signed [7:0]      right_stick_axis_i,
  input  logic signed [7:0]      right_trigger_i,
  input  logic [7:0]             drive_mode_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output tdm_pkg::track_cmd_t    cmd_o
);

  logic signed [8:0] steer9, lstick9, ltrig9, rstick9, rtrig9;
  logic signed [8:0] diff, abs_diff, factor;
  logic signed [8:0] rsum, lsum, rodd, lodd, half_r, half_l, drive9;
  logic signed [8:0] tr_other, tl_other;
  logic              diff_gt0, diff_pos, diff_neg, mix;

  // classify stage
  logic              s0_valid_q;
  logic              s0_mix_q, s0_diff_pos_q, s0_diff_neg_q, s0_reduced_q;
  logic signed [7:0] s0_drive_q;
  logic signed [8:0] s0_factor_q, s0_tr_q, s0_tl_q;

  // product stage
  logic              s1_valid_q;
  logic              s1_mix_q, s1_diff_pos_q, s1_diff_neg_q, s1_reduced_q, s1_neg_q;
  logic signed [7:0] s1_drive_q;
  logic [13:0]       s1_mag_q;
  logic signed [8:0] s1_tr_q, s1_tl_q;

  logic signed [16:0] prod;
  logic [16:0]        prod_mag;
  logic [28:0]        quot_prod;
  logic [7:0]         quot;
  logic signed [8:0]  scaled, drive_ext, tr, tl;
  logic               s0_ready, s1_ready;

  assign s1_ready   = !s1_valid_q || cmd_ready_i;
  assign s0_ready   = !s0_valid_q || s1_ready;
  assign in_ready_o = s0_ready;

  always_comb begin
    steer9  = {steer_axis_i[7], steer_axis_i};
    lstick9 = {left_stick_axis_i[7], left_stick_axis_i};
    ltrig9  = {left_trigger_i[7], left_trigger_i};
    rstick9 = {right_stick_axis_i[7], right_stick_axis_i};
    rtrig9  = {right_trigger_i[7], right_trigger_i};

    diff     = tdm_pkg::dead_zone(steer9, cfg_i.steer_dz);
    abs_diff = diff[8] ? -diff : diff;
    factor   = tdm_pkg::MixFullScale - abs_diff;

    // halve toward zero
    rsum   = rtrig9 + tdm_pkg::TrigOffset;
    lsum   = ltrig9 + tdm_pkg::TrigOffset;
    rodd   = rsum + $signed({8'b0, rsum[8]});
    lodd   = lsum + $signed({8'b0, lsum[8]});
    half_r = rodd >>> 1;
    half_l = lodd >>> 1;
    drive9 = half_r - half_l;

    diff_gt0 = !diff[8] && (diff != 9'sd0);
    diff_pos = drive9[8] ? diff[8] : diff_gt0;
    diff_neg = drive9[8] ? diff_gt0 : diff[8];

    mix = drive_mode_i inside {tdm_pkg::MODE_MIX_FULL, tdm_pkg::MODE_MIX_REDUCED};

    case (drive_mode_i)
      tdm_pkg::MODE_STICKS: begin
        tr_other = -rstick9;
        tl_other = -lstick9;
      end
      tdm_pkg::MODE_ARROWS: begin
        tr_other = tdm_pkg::arrow_right_target(
          {arrow_left_i, arrow_down_i, arrow_right_i, arrow_up_i});
        tl_other = tdm_pkg::arrow_left_target(
          {arrow_left_i, arrow_down_i, arrow_right_i, arrow_up_i});
      end
      tdm_pkg::MODE_TRIG_HALF: begin
        tr_other = half_r;
        tl_other = half_l;
      end
      tdm_pkg::MODE_TRIG_INV: begin
        tr_other = tdm_pkg::TrigOffset - rtrig9;
        tl_other = tdm_pkg::TrigOffset - ltrig9;
      end
      default: begin
        tr_other = 9'sd0;
        tl_other = 9'sd0;
      end
    endcase
  end

  assign prod     = 17'(s0_drive_q) * 17'(s0_factor_q);
  assign prod_mag = prod[16] ? 17'(-prod) : 17'(prod);

  assign quot_prod = 29'(s1_mag_q) * 29'(tdm_pkg::MixDivK);
  assign quot      = quot_prod[tdm_pkg::MixDivShift +: 8];
  assign scaled    = s1_neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign drive_ext = {s1_drive_q[7], s1_drive_q};
  assign tr        = s1_mix_q ? (s1_diff_pos_q ? scaled : drive_ext) : s1_tr_q;
  assign tl        = s1_mix_q ? (s1_diff_neg_q ? scaled : drive_ext) : s1_tl_q;

  assign cmd_valid_o        = s1_valid_q;
  assign cmd_o.right_target = tr;
  assign cmd_o.left_target  = tl;
  assign cmd_o.reduced      = s1_reduced_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_q <= in_valid_i;
      end
      if (s1_ready) begin
        s1_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i) begin
      s0_mix_q      <= mix;
      s0_diff_pos_q <= diff_pos;
      s0_diff_neg_q <= diff_neg;
      s0_reduced_q  <= (drive_mode_i == tdm_pkg::MODE_MIX_REDUCED);
      s0_drive_q    <= drive9[7:0];
      s0_factor_q   <= factor;
      s0_tr_q       <= tr_other;
      s0_tl_q       <= tl_other;
    end
    if (s1_ready && s0_valid_q) begin
      s1_mix_q      <= s0_mix_q;
      s1_diff_pos_q <= s0_diff_pos_q;
      s1_diff_neg_q <= s0_diff_neg_q;
      s1_reduced_q  <= s0_reduced_q;
      s1_neg_q      <= prod[16];
      s1_mag_q      <= prod_mag[13:0];
      s1_drive_q    <= s0_drive_q;
      s1_tr_q       <= s0_tr_q;
      s1_tl_q       <= s0_tl_q;
    end
  end

endmodule

### hdl/tdm_back.sv
module tdm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdm_pkg::cfg_t       cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  tdm_pkg::track_cmd_t cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                right_run_o,
  output logic                right_forward_o,
  output logic [16:0]         right_speed_hz_o,
  output logic                left_run_o,
  output logic                left_forward_o,
  output logic [16:0]         left_speed_hz_o
);

  logic signed [8:0] tr, tl;
  logic [8:0]        mag_r9, mag_l9;

  logic        b1_valid_q, b2_valid_q, b3_valid_q;
  logic        b1_ready, b2_ready, b3_ready;
  logic [15:0] b1_rate_q;
  logic [7:0]  b1_mag_r_q, b1_mag_l_q;
  logic        b1_run_r_q, b1_run_l_q, b1_fwd_r_q, b1_fwd_l_q;
  logic [23:0] b2_prod_r_q, b2_prod_l_q;
  logic        b2_run_r_q, b2_run_l_q, b2_fwd_r_q, b2_fwd_l_q;

  logic [44:0] div_r, div_l;
  logic [17:0] quot_r, quot_l;
  logic [16:0] speed_r, speed_l;

  assign b3_ready    = !b3_valid_q || out_ready_i;
  assign b2_ready    = !b2_valid_q || b3_ready;
  assign b1_ready    = !b1_valid_q || b2_ready;
  assign cmd_ready_o = b1_ready;

  assign tr     = tdm_pkg::dead_zone($signed(cmd_i.right_target), cfg_i.track_dz);
  assign tl     = tdm_pkg::dead_zone($signed(cmd_i.left_target), cfg_i.track_dz);
  assign mag_r9 = tr[8] ? 9'(-tr) : 9'(tr);
  assign mag_l9 = tl[8] ? 9'(-tl) : 9'(tl);

  // divide by 100 as a shift by two and a reciprocal multiply by 25
  assign div_r   = 45'(b2_prod_r_q[23:2]) * 45'(tdm_pkg::SpeedDivK);
  assign div_l   = 45'(b2_prod_l_q[23:2]) * 45'(tdm_pkg::SpeedDivK);
  assign quot_r  = div_r[tdm_pkg::SpeedDivShift +: 18];
  assign quot_l  = div_l[tdm_pkg::SpeedDivShift +: 18];
  assign speed_r = (quot_r > 18'(tdm_pkg::SpeedMax)) ? tdm_pkg::SpeedMax : quot_r[16:0];
  assign speed_l = (quot_l > 18'(tdm_pkg::SpeedMax)) ? tdm_pkg::SpeedMax : quot_l[16:0];

  assign out_valid_o = b3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_valid_q <= cmd_valid_i;
      end
      if (b2_ready) begin
        b2_valid_q <= b1_valid_q;
      end
      if (b3_ready) begin
        b3_valid_q <= b2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_ready && cmd_valid_i) begin
      b1_rate_q  <= cmd_i.reduced ? cfg_i.reduced_rate : cfg_i.full_rate;
      b1_mag_r_q <= mag_r9[7:0];
      b1_mag_l_q <= mag_l9[7:0];
      b1_run_r_q <= (tr != 9'sd0);
      b1_run_l_q <= (tl != 9'sd0);
      b1_fwd_r_q <= !tr[8] && (tr != 9'sd0);
      b1_fwd_l_q <= tl[8];
    end
    if (b2_ready && b1_valid_q) begin
      b2_prod_r_q <= 24'(b1_rate_q) * 24'(b1_mag_r_q);
      b2_prod_l_q <= 24'(b1_rate_q) * 24'(b1_mag_l_q);
      b2_run_r_q  <= b1_run_r_q;
      b2_run_l_q  <= b1_run_l_q;
      b2_fwd_r_q  <= b1_fwd_r_q;
      b2_fwd_l_q  <= b1_fwd_l_q;
    end
    if (b3_ready && b2_valid_q) begin
      right_run_o      <= b2_run_r_q;
      right_forward_o  <= b2_fwd_r_q;
      right_speed_hz_o <= speed_r;
      left_run_o       <= b2_run_l_q;
      left_forward_o   <= b2_fwd_l_q;
      left_speed_hz_o  <= speed_l;
    end
  end

endmodule

### hdl/tank_drive_track_mixer_unit.sv
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// command  | in_valid_i/in_ready_o  | arrows, five signed axes, drive_mode_i
// result   | out_valid_o/out_ready_i| run, forward, speed_hz for right and left
// config   | cfg_we_i               | cfg_idx_i, cfg_wdata_i (write only)
//
// one transaction per cycle sustained while out_ready_i stays high; a command
// passes two front stages, the queue and three back stages (two multipliers)
// reset clears the valid flags and the queue and loads the rate and dead zone defaults
// either side may stall; the queue between front and back absorbs the difference
module tank_drive_track_mixer_unit #(
  parameter int unsigned QueueDepth = tdm_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              arrow_up_i,
  input  logic              arrow_right_i,
  input  logic              arrow_down_i,
  input  logic              arrow_left_i,
  input  logic signed [7:0] steer_axis_i,
  input  logic signed [7:0] left_stick_axis_i,
  input  logic signed [7:0] left_trigger_i,
  input  logic signed [7:0] right_stick_axis_i,
  input  logic signed [7:0] right_trigger_i,
  input  logic [7:0]        drive_mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              right_run_o,
  output logic              right_forward_o,
  output logic [16:0]       right_speed_hz_o,
  output logic              left_run_o,
  output logic              left_forward_o,
  output logic [16:0]       left_speed_hz_o
);

  localparam int unsigned CmdW = $bits(tdm_pkg::track_cmd_t);

  tdm_pkg::cfg_t       cfg_q;
  tdm_pkg::track_cmd_t front_cmd, back_cmd;
  logic                front_valid, front_ready, back_valid, back_ready;
  logic [CmdW-1:0]     back_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_rate    <= tdm_pkg::FullRateReset;
      cfg_q.reduced_rate <= tdm_pkg::ReducedRateReset;
      cfg_q.track_dz     <= tdm_pkg::TrackDzReset;
      cfg_q.steer_dz     <= tdm_pkg::SteerDzReset;
    end else if (cfg_we_i) begin
      case (tdm_pkg::cfg_reg_e'(cfg_idx_i))
        tdm_pkg::REG_FULL_RATE:    cfg_q.full_rate    <= cfg_wdata_i;
        tdm_pkg::REG_REDUCED_RATE: cfg_q.reduced_rate <= cfg_wdata_i;
        tdm_pkg::REG_TRACK_DZ:     cfg_q.track_dz     <= cfg_wdata_i[6:0];
        tdm_pkg::REG_STEER_DZ:     cfg_q.steer_dz     <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  tdm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .arrow_up_i         (arrow_up_i),
    .arrow_right_i      (arrow_right_i),
    .arrow_down_i       (arrow_down_i),
    .arrow_left_i       (arrow_left_i),
    .steer_axis_i       (steer_axis_i),
    .left_stick_axis_i  (left_stick_axis_i),
    .left_trigger_i     (left_trigger_i),
    .right_stick_axis_i (right_stick_axis_i),
    .right_trigger_i    (right_trigger_i),
    .drive_mode_i       (drive_mode_i),
    .cmd_valid_o        (front_valid),
    .cmd_ready_i        (front_ready),
    .cmd_o              (front_cmd)
  );

  tdm_queue #(
    .Width (CmdW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_data_o  (back_bits)
  );

  assign back_cmd = tdm_pkg::track_cmd_t'(back_bits);

  tdm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_valid_i      (back_valid),
    .cmd_ready_o      (back_ready),
    .cmd_i            (back_cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .right_run_o      (right_run_o),
    .right_forward_o  (right_forward_o),
    .right_speed_hz_o (right_speed_hz_o),
    .left_run_o       (left_run_o),
    .left_forward_o   (left_forward_o),
    .left_speed_hz_o  (left_speed_hz_o)
  );

endmodule

### tb/tank_drive_track_mixer_unit_tb.sv
module tank_drive_track_mixer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdm_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int SpeedCap = 131071;
  localparam int PhaseCount = 8;
  localparam int PhaseItems = 75;

  typedef struct {
    logic              up;
    logic              right;
    logic              down;
    logic              left;
    logic signed [7:0] steer;
    logic signed [7:0] lstick;
    logic signed [7:0] ltrig;
    logic signed [7:0] rstick;
    logic signed [7:0] rtrig;
    logic [7:0]        mode;
  } cmd_t;

  typedef struct {
    logic        r_run;
    logic        r_fwd;
    logic [16:0] r_spd;
    logic        l_run;
    logic        l_fwd;
    logic [16:0] l_spd;
  } track_pair_t;

  typedef struct {
    cmd_t        cmd;
    bit          typed;
    track_pair_t want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [15:0]       cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              arrow_up_i = 1'b0;
  logic              arrow_right_i = 1'b0;
  logic              arrow_down_i = 1'b0;
  logic              arrow_left_i = 1'b0;
  logic signed [7:0] steer_axis_i = '0;
  logic signed [7:0] left_stick_axis_i = '0;
  logic signed [7:0] left_trigger_i = '0;
  logic signed [7:0] right_stick_axis_i = '0;
  logic signed [7:0] right_trigger_i = '0;
  logic [7:0]        drive_mode_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              right_run_o;
  logic              right_forward_o;
  logic [16:0]       right_speed_hz_o;
  logic              left_run_o;
  logic              left_forward_o;
  logic [16:0]       left_speed_hz_o;

  logic [15:0] cur_full = FullRateReset;
  logic [15:0] cur_reduced = ReducedRateReset;
  logic [6:0]  cur_tdz = TrackDzReset;
  logic [6:0]  cur_sdz = SteerDzReset;

  track_pair_t predicted_tracks[$];
  dir_row_t    dir_rows[$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;

  tank_drive_track_mixer_unit DUT (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int idle_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 96) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic int dz_off(int x, int z);
    if (x < z && x > -z) return 0;
    return (x > 0) ? x - z : x + z;
  endfunction

  function automatic void track_drive(input int target, input int rate, input bit mirrored,
                                      output logic run, output logic fwd,
                                      output logic [16:0] spd);
    int v;
    int s;
    v = dz_off(target, int'(cur_tdz));
    run = 1'b0;
    fwd = 1'b0;
    spd = '0;
    if (v != 0) begin
      s = rate * ((v < 0) ? -v : v) / 100;
      if (s > SpeedCap) s = SpeedCap;
      run = 1'b1;
      fwd = mirrored ? (v < 0) : (v > 0);
      spd = 17'(s);
    end
  endfunction

  function automatic track_pair_t mix_tracks(cmd_t c);
    track_pair_t p;
    int rate;
    int tr;
    int tl;
    int diff;
    int drive;
    int scaled;
    int rt;
    int lt;
    rt = int'(c.rtrig);
    lt = int'(c.ltrig);
    rate = (c.mode == MODE_MIX_REDUCED) ? int'(cur_reduced) : int'(cur_full);
    tr = 0;
    tl = 0;
    case (c.mode)
      MODE_MIX_FULL, MODE_MIX_REDUCED: begin
        diff = dz_off(int'(c.steer), int'(cur_sdz));
        drive = (rt + 100) / 2 - (lt + 100) / 2;
        if (drive < 0) diff = -diff;
        scaled = drive * (101 - ((diff < 0) ? -diff : diff)) / 101;
        tr = (diff > 0) ? scaled : drive;
        tl = (diff < 0) ? scaled : drive;
      end
      MODE_STICKS: begin
        tr = -int'(c.rstick);
        tl = -int'(c.lstick);
      end
      MODE_ARROWS: begin
        case ({c.left, c.down, c.right, c.up})
          4'b0001: begin tr = 100;  tl = 100;  end
          4'b0010: begin tr = -100; tl = 100;  end
          4'b0011: begin tr = 0;    tl = 100;  end
          4'b0100: begin tr = -100; tl = -100; end
          4'b0110: begin tr = 0;    tl = -100; end
          4'b1000: begin tr = 100;  tl = -100; end
          4'b1001: begin tr = 100;  tl = 0;    end
          4'b1100: begin tr = -100; tl = 0;    end
          default: begin tr = 0;    tl = 0;    end
        endcase
      end
      MODE_TRIG_HALF: begin
        tr = (rt + 100) / 2;
        tl = (lt + 100) / 2;
      end
      MODE_TRIG_INV: begin
        tr = 100 - rt;
        tl = 100 - lt;
      end
      default: begin
        tr = 0;
        tl = 0;
      end
    endcase
    track_drive(tr, rate, 1'b0, p.r_run, p.r_fwd, p.r_spd);
    track_drive(tl, rate, 1'b1, p.l_run, p.l_fwd, p.l_spd);
    return p;
  endfunction

  function automatic cmd_t mk_cmd(bit up, bit rgt, bit dn, bit lft, int steer, int lstick,
                                  int ltrig, int rstick, int rtrig, int mode);
    cmd_t c;
    c.up = up;
    c.right = rgt;
    c.down = dn;
    c.left = lft;
    c.steer = 8'(steer);
    c.lstick = 8'(lstick);
    c.ltrig = 8'(ltrig);
    c.rstick = 8'(rstick);
    c.rtrig = 8'(rtrig);
    c.mode = 8'(mode);
    return c;
  endfunction

  function automatic track_pair_t mk_pair(bit rr, bit rf, int rs, bit lr, bit lf, int ls);
    track_pair_t p;
    p.r_run = rr;
    p.r_fwd = rf;
    p.r_spd = 17'(rs);
    p.l_run = lr;
    p.l_fwd = lf;
    p.l_spd = 17'(ls);
    return p;
  endfunction

  task automatic add_row(input cmd_t c, input bit typed, input track_pair_t want);
    dir_row_t row;
    row.cmd = c;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  function automatic logic signed [7:0] rand_axis();
    int r;
    r = int'($urandom_range(0, 15));
    if (r == 0) return -8'sd128;
    if (r == 1) return 8'sd127;
    if (r < 6) return 8'(int'($urandom_range(0, 24)) - 12);
    return 8'($urandom);
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c.up = 1'($urandom);
    c.right = 1'($urandom);
    c.down = 1'($urandom);
    c.left = 1'($urandom);
    c.steer = rand_axis();
    c.lstick = rand_axis();
    c.ltrig = rand_axis();
    c.rstick = rand_axis();
    c.rtrig = rand_axis();
    r = int'($urandom_range(0, 99));
    if (r < 20) c.mode = MODE_MIX_FULL;
    else if (r < 35) c.mode = MODE_MIX_REDUCED;
    else if (r < 50) c.mode = MODE_STICKS;
    else if (r < 65) c.mode = MODE_ARROWS;
    else if (r < 78) c.mode = MODE_TRIG_HALF;
    else if (r < 91) c.mode = MODE_TRIG_INV;
    else c.mode = 8'($urandom_range(6, 255));
    return c;
  endfunction

  task automatic build_rows();
    track_pair_t none;
    none = mk_pair(0, 0, 0, 0, 0, 0);
    // unknown modes and empty arrow combinations stop both tracks, then arrow and stick rows follow
    add_row(mk_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0, 6), 1, none);
    add_row(mk_cmd(1, 1, 1, 1, 127, -128, 127, -128, 127, 255), 1, none);
    add_row(mk_cmd(0, 0, 0, 0, -128, 127, -128, 127, -128, 7), 1, none);
    add_row(mk_cmd(0, 0, 0, 0, 50, 50, 50, 50, 50, MODE_ARROWS), 1, none);
    add_row(mk_cmd(1, 0, 0, 0, 0, 0, 0, 0, 0, MODE_ARROWS), 1,
            mk_pair(1, 1, 13950, 1, 0, 13950));
    add_row(mk_cmd(0, 1, 0, 0, 0, 0, 0, 0, 0, MODE_ARROWS), 1,
            mk_pair(1, 0, 13950, 1, 0, 13950));
    add_row(mk_cmd(0, 0, 1, 0, 0, 0, 0, 0, 0, MODE_ARROWS), 1,
            mk_pair(1, 0, 13950, 1, 1, 13950));
    add_row(mk_cmd(0, 0, 0, 1, 0, 0, 0, 0, 0, MODE_ARROWS), 1,
            mk_pair(1, 1, 13950, 1, 1, 13950));
    add_row(mk_cmd(1, 1, 0, 0, 0, 0, 0, 0, 0, MODE_ARROWS), 1,
            mk_pair(0, 0, 0, 1, 0, 13950));
    add_row(mk_cmd(1, 1, 1, 1, 0, 0, 0, 0, 0, MODE_ARROWS), 1, none);
    add_row(mk_cmd(0, 1, 1, 0, 0, 0, 0, 0, 0, MODE_ARROWS), 0, none);
    add_row(mk_cmd(0, 0, 0, 0, 0, 127, 0, -128, 0, MODE_STICKS), 1,
            mk_pair(1, 1, 18150, 1, 1, 18000));
    add_row(mk_cmd(0, 0, 0, 0, 0, -128, 0, 127, 0, MODE_STICKS), 1,
            mk_pair(1, 0, 18000, 1, 0, 18150));
    // targets right on the track dead zone edge
    add_row(mk_cmd(0, 0, 0, 0, 0, 7, 0, -7, 0, MODE_STICKS), 1, none);
    add_row(mk_cmd(0, 0, 0, 0, 0, 8, 0, -8, 0, MODE_STICKS), 0, none);
    add_row(mk_cmd(0, 0, 0, 0, 0, 0, -128, 0, -128, MODE_TRIG_HALF), 0, none);
    add_row(mk_cmd(0, 0, 0, 0, 0, 0, 127, 0, 127, MODE_TRIG_HALF), 0, none);
    add_row(mk_cmd(0, 0, 0, 0, 0, 0, 127, 0, -128, MODE_TRIG_INV), 0, none);
    add_row(mk_cmd(0, 0, 0, 0, 0, 0, -100, 0, 100, MODE_MIX_FULL), 0, none);
    add_row(mk_cmd(0, 0, 0, 0, 127, 0, -128, 0, 127, MODE_MIX_FULL), 0, none);
    add_row(mk_cmd(0, 0, 0, 0, -128, 0, 127, 0, -128, MODE_MIX_FULL), 0, none);
    add_row(mk_cmd(0, 0, 0, 0, 60, 0, -100, 0, 100, MODE_MIX_REDUCED), 0, none);
    add_row(mk_cmd(0, 0, 0, 0, -7, 0, 0, 0, 127, MODE_MIX_REDUCED), 0, none);
    add_row(mk_cmd(0, 0, 0, 0, -8, 0, -100, 0, -100, MODE_MIX_FULL), 0, none);
  endtask

  task automatic send_cmd(input cmd_t c, input bit typed, input track_pair_t want);
    int gap;
    gap = idle_len(quiet_in);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    arrow_up_i <= c.up;
    arrow_right_i <= c.right;
    arrow_down_i <= c.down;
    arrow_left_i <= c.left;
    steer_axis_i <= c.steer;
    left_stick_axis_i <= c.lstick;
    left_trigger_i <= c.ltrig;
    right_stick_axis_i <= c.rstick;
    right_trigger_i <= c.rtrig;
    drive_mode_i <= c.mode;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted_tracks.push_back(typed ? want : mix_tracks(c));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (predicted_tracks.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [15:0] full, input logic [15:0] reduced,
                           input logic [6:0] tdz, input logic [6:0] sdz);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_FULL_RATE;
    cfg_wdata_i <= full;
    @(posedge clk_i);
    cfg_idx_i <= REG_REDUCED_RATE;
    cfg_wdata_i <= reduced;
    @(posedge clk_i);
    cfg_idx_i <= REG_TRACK_DZ;
    cfg_wdata_i <= {9'd0, tdz};
    @(posedge clk_i);
    cfg_idx_i <= REG_STEER_DZ;
    cfg_wdata_i <= {9'd0, sdz};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_full = full;
    cur_reduced = reduced;
    cur_tdz = tdz;
    cur_sdz = sdz;
  endtask

  // result side: compare each transaction against the oldest prediction
  initial begin
    int hold;
    track_pair_t w;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (predicted_tracks.size() == 0) begin
          $error("result transaction with nothing pending");
          mismatch_cnt++;
        end else begin
          w = predicted_tracks.pop_front();
          if (right_run_o !== w.r_run) begin
            $error("right_run: expected %0d, actual %0d", w.r_run, right_run_o);
            mismatch_cnt++;
          end
          if (right_forward_o !== w.r_fwd) begin
            $error("right_forward: expected %0d, actual %0d", w.r_fwd, right_forward_o);
            mismatch_cnt++;
          end
          if (right_speed_hz_o !== w.r_spd) begin
            $error("right_speed_hz: expected %0d, actual %0d", w.r_spd, right_speed_hz_o);
            mismatch_cnt++;
          end
          if (left_run_o !== w.l_run) begin
            $error("left_run: expected %0d, actual %0d", w.l_run, left_run_o);
            mismatch_cnt++;
          end
          if (left_forward_o !== w.l_fwd) begin
            $error("left_forward: expected %0d, actual %0d", w.l_fwd, left_forward_o);
            mismatch_cnt++;
          end
          if (left_speed_hz_o !== w.l_spd) begin
            $error("left_speed_hz: expected %0d, actual %0d", w.l_spd, left_speed_hz_o);
            mismatch_cnt++;
          end
        end
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        hold = idle_len(quiet_out);
      end
    end
  end

  initial begin
    logic [15:0] full;
    logic [15:0] reduced;
    logic [6:0]  tdz;
    logic [6:0]  sdz;
    build_rows();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      send_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].want);
    end
    drain();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin full = 16'd50000; reduced = 16'd0;     tdz = 7'd0;   sdz = 7'd0;   end
        1: begin full = 16'd0;     reduced = 16'd50000; tdz = 7'd127; sdz = 7'd127; end
        // rates past the normal range drive the speed into saturation
        2: begin full = 16'hFFFF;  reduced = 16'hFFFF;  tdz = 7'd0;   sdz = 7'd127; end
        3: begin full = 16'hFFFF;  reduced = 16'hFFFF;  tdz = 7'd127; sdz = 7'd0;   end
        default: begin
          full = 16'($urandom_range(0, 50000));
          reduced = 16'($urandom_range(0, 50000));
          tdz = 7'($urandom_range(0, 127));
          sdz = 7'($urandom_range(0, 127));
        end
      endcase
      write_cfg(full, reduced, tdz, sdz);
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      repeat (PhaseItems) send_cmd(rand_cmd(), 1'b0, mk_pair(0, 0, 0, 0, 0, 0));
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
